// ===== rtl/core/bthist_pkg.sv =====
`default_nettype none

package bthist_pkg;

   localparam int MAX_BUCKETS_DEFAULT = 1024;

   localparam int COORD_W = 32;
   localparam int TIME_W  = 48;
   localparam int COUNT_W = 32;
   localparam int WIDTH_W = 32;
   localparam int CSR_W   = 48;
   localparam int RIDX_W  = 10;
   localparam int USE_W   = 11;

   // divider: dividend covers a time difference plus one bucket width
   localparam int DIVD_W    = TIME_W + 1;
   localparam int DIV_CNT_W = $clog2(DIVD_W);

   localparam logic [WIDTH_W-1:0] BUCKET_WIDTH_RESET = 32'd1000;

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [2:0] CSR_BOX_MIN_X    = 3'd0;
   localparam logic [2:0] CSR_BOX_MAX_X    = 3'd1;
   localparam logic [2:0] CSR_BOX_MIN_Y    = 3'd2;
   localparam logic [2:0] CSR_BOX_MAX_Y    = 3'd3;
   localparam logic [2:0] CSR_WINDOW_START = 3'd4;
   localparam logic [2:0] CSR_WINDOW_END   = 3'd5;
   localparam logic [2:0] CSR_BUCKET_WIDTH = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/core/bthist_ram.sv =====
`default_nettype none

module bthist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AddrW-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AddrW-1:0]      rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/box_time_bucket_histogram_unit.sv =====
`default_nettype none

// Time-bucket histogram with a box and time-window filter. Counters live in
// one single-port-read RAM of MAX_BUCKETS x 32 bits. After reset, and after
// every clear item, a clearing pass writes zero to every counter, one per cycle;
// req_ready stays low meanwhile (CSR writes still land). An unused request
// code ends after decode. A record item is decoded, then runs 49 steps of
// the bit-serial divider that yields the bucket index, then a counter read
// and a saturating write. A point outside the box or window ends after
// decode, one past the last bucket in use after the divider. A read item
// waits for rsp_ready while the output register still holds the previous
// response; a pending response does not stop the next item from being
// accepted. After a CSR write to a defined index the bucket count in use is
// recomputed on the same divider before the next item is accepted; an empty
// or reversed window skips the divider.
module box_time_bucket_histogram_unit #(
   parameter int MAX_BUCKETS = bthist_pkg::MAX_BUCKETS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              csr_we,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [bthist_pkg::CSR_W-1:0]      csr_wdata,

   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [1:0]                        req_type,
   input  wire logic [bthist_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic [bthist_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic [bthist_pkg::TIME_W-1:0]     req_point_time,
   input  wire logic [bthist_pkg::RIDX_W-1:0]     req_read_index,

   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [bthist_pkg::COUNT_W-1:0]    rsp_bucket_count,
   output      logic [bthist_pkg::USE_W-1:0]      rsp_buckets_in_use,
   output      logic                              rsp_index_in_range
);

   localparam int AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW    = $clog2(MAX_BUCKETS + 1);
   localparam int CW    = bthist_pkg::COORD_W;
   localparam int TW    = bthist_pkg::TIME_W;
   localparam int KW    = bthist_pkg::COUNT_W;
   localparam int WW    = bthist_pkg::WIDTH_W;
   localparam int DW    = bthist_pkg::DIVD_W;
   localparam int RW    = bthist_pkg::RIDX_W;
   localparam int UW    = bthist_pkg::USE_W;
   localparam int DCW   = bthist_pkg::DIV_CNT_W;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_NPREP = 4'd2;
   localparam logic [3:0] ST_NLOAD = 4'd3;
   localparam logic [3:0] ST_NDIV  = 4'd4;
   localparam logic [3:0] ST_NFIN  = 4'd5;
   localparam logic [3:0] ST_DEC   = 4'd6;
   localparam logic [3:0] ST_PDIV  = 4'd7;
   localparam logic [3:0] ST_PFIN  = 4'd8;
   localparam logic [3:0] ST_PWR   = 4'd9;
   localparam logic [3:0] ST_RESP  = 4'd10;

   localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);
   localparam logic [AW-1:0]  CLR_LAST = AW'(MAX_BUCKETS - 1);

   // configuration
   logic [CW-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic [CW-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [TW-1:0] win_start_ff, win_start_in, win_end_ff, win_end_in;
   logic [WW-1:0] bwidth_ff, bwidth_in;

   // control
   logic [3:0]    state_ff, state_in;
   logic          dirty_ff, dirty_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] nuse_ff, nuse_in;
   logic [DW-1:0] diff_ff, diff_in;

   // captured item
   logic [1:0]    type_ff, type_in;
   logic [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic [TW-1:0] pt_ff, pt_in;
   logic [RW-1:0] ri_ff, ri_in;

   // divider
   logic [WW-1:0]  drem_ff, drem_in;
   logic [DW-1:0]  dquo_ff, dquo_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0] rsp_count_ff, rsp_count_in;
   logic [UW-1:0] rsp_use_ff, rsp_use_in;
   logic          rsp_range_ff, rsp_range_in;

   // ram
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [KW-1:0] ram_wdata, ram_rdata;

   logic              accept;
   logic [WW-1:0]     weff;
   logic [WW:0]       rshift;
   logic [WW+1:0]     trial;
   logic [DW-1:0]     tdiff;
   logic              pass;
   logic [NW+UW-1:0]  nuse_ext;
   logic [AW+RW-1:0]  ri_ext;

   bthist_ram #(
      .WIDTH(KW),
      .DEPTH(MAX_BUCKETS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE) && !dirty_ff;
   assign accept    = req_valid && req_ready;

   assign weff   = (bwidth_ff == '0) ? WW'(1) : bwidth_ff;
   assign rshift = {drem_ff, dquo_ff[DW-1]};
   assign trial  = {1'b0, rshift} - {2'b00, weff};

   assign tdiff = {pt_ff[TW-1], pt_ff} - {win_start_ff[TW-1], win_start_ff};
   assign pass  = ($signed(px_ff) >= $signed(min_x_ff)) && ($signed(px_ff) <= $signed(max_x_ff)) &&
                  ($signed(py_ff) >= $signed(min_y_ff)) && ($signed(py_ff) <= $signed(max_y_ff)) &&
                  ($signed(pt_ff) >= $signed(win_start_ff)) &&
                  ($signed(pt_ff) <= $signed(win_end_ff));

   assign nuse_ext = (NW + UW)'(nuse_ff);
   assign ri_ext   = (AW + RW)'(ri_ff);

   always_comb begin
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      bwidth_in    = bwidth_ff;
      dirty_in     = dirty_ff;
      if (csr_we) begin
         dirty_in = 1'b1;
         case (csr_index)
            bthist_pkg::CSR_BOX_MIN_X:    min_x_in     = csr_wdata[CW-1:0];
            bthist_pkg::CSR_BOX_MAX_X:    max_x_in     = csr_wdata[CW-1:0];
            bthist_pkg::CSR_BOX_MIN_Y:    min_y_in     = csr_wdata[CW-1:0];
            bthist_pkg::CSR_BOX_MAX_Y:    max_y_in     = csr_wdata[CW-1:0];
            bthist_pkg::CSR_WINDOW_START: win_start_in = csr_wdata[TW-1:0];
            bthist_pkg::CSR_WINDOW_END:   win_end_in   = csr_wdata[TW-1:0];
            bthist_pkg::CSR_BUCKET_WIDTH: bwidth_in    = csr_wdata[WW-1:0];
            default: dirty_in = dirty_ff;
         endcase
      end else if (state_ff == ST_IDLE && dirty_ff) begin
         dirty_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      nuse_in      = nuse_ff;
      diff_in      = diff_ff;
      type_in      = type_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pt_in        = pt_ff;
      ri_in        = ri_ff;
      drem_in      = drem_ff;
      dquo_in      = dquo_ff;
      dcnt_in      = dcnt_ff;
      rsp_count_in = rsp_count_ff;
      rsp_use_in   = rsp_use_ff;
      rsp_range_in = rsp_range_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = dquo_ff[AW-1:0];
      ram_wdata    = (ram_rdata == '1) ? ram_rdata : ram_rdata + KW'(1);
      ram_re       = 1'b0;
      ram_raddr    = dquo_ff[AW-1:0];

      if (state_ff == ST_NDIV || state_ff == ST_PDIV) begin
         dquo_in = {dquo_ff[DW-2:0], !trial[WW+1]};
         drem_in = trial[WW+1] ? rshift[WW-1:0] : trial[WW-1:0];
         dcnt_in = dcnt_ff + DCW'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (dirty_ff) begin
               state_in = ST_NPREP;
            end else if (accept) begin
               type_in  = req_type;
               px_in    = req_point_x;
               py_in    = req_point_y;
               pt_in    = req_point_time;
               ri_in    = req_read_index;
               state_in = ST_DEC;
            end
         end
         ST_NPREP: begin
            diff_in  = {win_end_ff[TW-1], win_end_ff} - {win_start_ff[TW-1], win_start_ff};
            state_in = ST_NLOAD;
         end
         ST_NLOAD: begin
            if (diff_ff[DW-1] || diff_ff == '0) begin
               nuse_in  = '0;
               state_in = ST_IDLE;
            end else begin
               dquo_in  = diff_ff + DW'(weff) - DW'(1);
               drem_in  = '0;
               dcnt_in  = '0;
               state_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_NFIN;
            end
         end
         ST_NFIN: begin
            nuse_in  = (dquo_ff > DW'(MAX_BUCKETS)) ? NW'(MAX_BUCKETS) : dquo_ff[NW-1:0];
            state_in = ST_IDLE;
         end
         ST_DEC: begin
            case (type_ff)
               bthist_pkg::REQ_RECORD: begin
                  if (pass) begin
                     dquo_in  = tdiff;
                     drem_in  = '0;
                     dcnt_in  = '0;
                     state_in = ST_PDIV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               bthist_pkg::REQ_READ: begin
                  ram_re    = 1'b1;
                  ram_raddr = ri_ext[AW-1:0];
                  state_in  = ST_RESP;
               end
               bthist_pkg::REQ_CLEAR: begin
                  clr_cnt_in = '0;
                  state_in   = ST_CLEAR;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PDIV: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_PFIN;
            end
         end
         ST_PFIN: begin
            if (dquo_ff < DW'(nuse_ff)) begin
               ram_re   = 1'b1;
               state_in = ST_PWR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PWR: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = (32'(ri_ff) < 32'(MAX_BUCKETS)) ? ram_rdata : '0;
               rsp_use_in   = nuse_ext[UW-1:0];
               rsp_range_in = 32'(ri_ff) < 32'(nuse_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         dirty_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         nuse_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         min_x_ff     <= '0;
         max_x_ff     <= '0;
         min_y_ff     <= '0;
         max_y_ff     <= '0;
         win_start_ff <= '0;
         win_end_ff   <= '0;
         bwidth_ff    <= bthist_pkg::BUCKET_WIDTH_RESET;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         clr_cnt_ff   <= clr_cnt_in;
         nuse_ff      <= nuse_in;
         rsp_valid_ff <= rsp_valid_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         bwidth_ff    <= bwidth_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff      <= diff_in;
      type_ff      <= type_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pt_ff        <= pt_in;
      ri_ff        <= ri_in;
      drem_ff      <= drem_in;
      dquo_ff      <= dquo_in;
      dcnt_ff      <= dcnt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_use_ff   <= rsp_use_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bucket_count   = rsp_count_ff;
   assign rsp_buckets_in_use = rsp_use_ff;
   assign rsp_index_in_range = rsp_range_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_rmw_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PWR) |-> ($past(ram_re) && $past(ram_raddr) == ram_waddr))
      else $error("counter write without matching read");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response raised outside response state");

   a_nuse_capped: assert property (@(posedge clock) disable iff (reset)
      32'(nuse_ff) <= 32'(MAX_BUCKETS))
      else $error("bucket count in use above maximum");

   a_no_accept_when_dirty: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == bthist_pkg::CSR_BUCKET_WIDTH) |=> !req_ready)
      else $error("item accepted before bucket count recomputed");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bthist_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int NBUCKETS = MAX_BUCKETS_DEFAULT;
   localparam int QUIET_CYCLES = 1100;
   localparam int RANDOM_SETUPS = 5;
   localparam int ITEMS_PER_SETUP = 100;
   localparam longint COORD_LO = -(longint'(1) << 31);
   localparam longint COORD_HI = (longint'(1) << 31) - 1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] x;
      logic [31:0] y;
      logic [47:0] t;
      logic [9:0]  ridx;
   } hist_req_type;

   typedef struct packed {
      logic [31:0] count;
      logic [10:0] in_use;
      logic        in_range;
   } bucket_read_type;

   class bucket_tally;
      logic signed [31:0] min_x, max_x, min_y, max_y;
      logic signed [47:0] win_start, win_end;
      logic [31:0]        bwidth;
      logic [31:0]        counters [NBUCKETS];
      bucket_read_type    pending_reads [$];
      int unsigned        failures, reads_checked, points_binned, clears_seen, transfers;

      function new();
         min_x = 0;
         max_x = 0;
         min_y = 0;
         max_y = 0;
         win_start = 0;
         win_end = 0;
         bwidth = BUCKET_WIDTH_RESET;
         foreach (counters[i]) counters[i] = '0;
      endfunction

      function longint unsigned step_width();
         return (bwidth == 0) ? 1 : longint'(bwidth);
      endfunction

      function longint unsigned span_count();
         longint s, e;
         longint unsigned d, q;
         s = win_start;
         e = win_end;
         if (e <= s) return 0;
         d = e - s;
         q = (d + step_width() - 1) / step_width();
         return (q > NBUCKETS) ? NBUCKETS : q;
      endfunction

      function void set_reg(logic [2:0] idx, logic [47:0] v);
         case (idx)
            CSR_BOX_MIN_X:    min_x = v[31:0];
            CSR_BOX_MAX_X:    max_x = v[31:0];
            CSR_BOX_MIN_Y:    min_y = v[31:0];
            CSR_BOX_MAX_Y:    max_y = v[31:0];
            CSR_WINDOW_START: win_start = v;
            CSR_WINDOW_END:   win_end = v;
            CSR_BUCKET_WIDTH: bwidth = v[31:0];
            default: ;
         endcase
      endfunction

      function void take_request(hist_req_type r);
         longint x, y, t, s, e;
         longint unsigned n, idx;
         n = span_count();
         transfers++;
         case (r.kind)
            REQ_RECORD: begin
               x = $signed(r.x);
               y = $signed(r.y);
               t = $signed(r.t);
               s = win_start;
               e = win_end;
               if (x >= min_x && x <= max_x && y >= min_y && y <= max_y &&
                   t >= s && t <= e) begin
                  idx = longint'(t - s) / step_width();
                  if (idx < n) begin
                     if (counters[idx] != '1) counters[idx]++;
                     points_binned++;
                  end
               end
            end
            REQ_READ: begin
               pending_reads.push_back('{count: counters[r.ridx], in_use: n[10:0],
                                         in_range: (r.ridx < n)});
            end
            REQ_CLEAR: begin
               foreach (counters[i]) counters[i] = '0;
               clears_seen++;
            end
            default: ;
         endcase
      endfunction

      function void check_reading(logic [31:0] count, logic [10:0] in_use, logic in_range);
         bucket_read_type want;
         if (pending_reads.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected result count=%0d in_use=%0d in_range=%0b",
                        $realtime, count, in_use, in_range);
            return;
         end
         want = pending_reads.pop_front();
         reads_checked++;
         if (want.count !== count || want.in_use !== in_use || want.in_range !== in_range) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch exp count=%0d in_use=%0d in_range=%0b, got %0d %0d %0b",
                        $realtime, want.count, want.in_use, want.in_range,
                        count, in_use, in_range);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_RECORD;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic [47:0] req_point_time = '0;
   logic [9:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_bucket_count;
   logic [10:0] rsp_buckets_in_use;
   logic        rsp_index_in_range;

   bucket_tally tally;
   logic [47:0] cfg_vals [7];
   int unsigned burst_left = 0;
   int unsigned rx_run = 0;
   logic [11:0] rx_tick = '0;

   box_time_bucket_histogram_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_time     (req_point_time),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bucket_count   (rsp_bucket_count),
      .rsp_buckets_in_use (rsp_buckets_in_use),
      .rsp_index_in_range (rsp_index_in_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall runs, with long fully-open stretches
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_run != 0) begin
         rx_run <= rx_run - 1;
      end else if (rx_tick[10]) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 1) == 1);
         rx_run <= $urandom_range(0, 15);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tally.check_reading(rsp_bucket_count, rsp_buckets_in_use, rsp_index_in_range);
   end

   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned span, r;
      if (hi <= lo) return lo;
      span = hi - lo + 1;
      r = {$urandom, $urandom};
      return lo + longint'(r % span);
   endfunction

   function automatic hist_req_type req_item(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                                             logic [47:0] t, logic [9:0] ridx);
      return '{kind: kind, x: x, y: y, t: t, ridx: ridx};
   endfunction

   task automatic send_item(input hist_req_type r);
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_point_x <= r.x;
      req_point_y <= r.y;
      req_point_time <= r.t;
      req_read_index <= r.ridx;
      do @(posedge clock); while (!req_ready);
      tally.take_request(r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 9) < 7)
            repeat ($urandom_range(1, 3)) @(posedge clock);
         else
            repeat ($urandom_range(5, 40)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tally.pending_reads.size() != 0) @(posedge clock);
   endtask

   task automatic settle_and_program();
      drain_results();
      // records and clears leave no result behind; let them finish
      repeat (QUIET_CYCLES) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= cfg_vals[i];
         tally.set_reg(3'(i), cfg_vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic pick_setup();
      longint c, hw, lo, hi, w, s, e;
      c = rand_between(COORD_LO, COORD_HI);
      hw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1 << 26);
      lo = (c - hw < COORD_LO) ? COORD_LO : c - hw;
      hi = (c + hw > COORD_HI) ? COORD_HI : c + hw;
      cfg_vals[CSR_BOX_MIN_X] = ($urandom_range(0, 9) == 0) ? 48'(hi) : 48'(lo);
      cfg_vals[CSR_BOX_MAX_X] = 48'(hi);
      c = rand_between(COORD_LO, COORD_HI);
      hw = $urandom_range(0, 1 << 26);
      lo = (c - hw < COORD_LO) ? COORD_LO : c - hw;
      hi = (c + hw > COORD_HI) ? COORD_HI : c + hw;
      cfg_vals[CSR_BOX_MIN_Y] = 48'(lo);
      cfg_vals[CSR_BOX_MAX_Y] = 48'(hi);
      case ($urandom_range(0, 2))
         0: w = 1;
         1: w = $urandom_range(1, 60);
         default: w = $urandom_range(1, 100000);
      endcase
      s = rand_between(-(longint'(1) << 46), longint'(1) << 46);
      if ($urandom_range(0, 11) == 0)
         e = s - $urandom_range(0, 1000);
      else
         e = s + longint'($urandom_range(0, 1100)) * w - $urandom_range(0, w - 1);
      cfg_vals[CSR_WINDOW_START] = 48'(s);
      cfg_vals[CSR_WINDOW_END] = 48'(e);
      cfg_vals[CSR_BUCKET_WIDTH] = 48'(w);
   endtask

   function automatic hist_req_type random_item();
      hist_req_type r;
      longint s, e, tmax;
      longint unsigned n;
      int unsigned pick;
      r = req_item(REQ_RECORD, $urandom, $urandom, 48'({$urandom, $urandom}), 10'($urandom));
      n = tally.span_count();
      s = tally.win_start;
      e = tally.win_end;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         if ($urandom_range(0, 4) != 0) begin
            if (tally.min_x <= tally.max_x)
               r.x = 32'(rand_between(tally.min_x, tally.max_x));
            r.y = 32'(rand_between(tally.min_y, tally.max_y));
            if (e >= s) begin
               tmax = e;
               if ($urandom_range(0, 1) == 1 && s + 4 * longint'(tally.step_width()) < e)
                  tmax = s + 4 * longint'(tally.step_width());
               r.t = 48'(rand_between(s, tmax));
            end
         end
      end else if (pick < 90) begin
         r.kind = REQ_READ;
         if (n != 0 && $urandom_range(0, 2) != 0)
            r.ridx = 10'(rand_between(0, (n > 8 && $urandom_range(0, 1) == 1) ? 7 : n - 1));
      end else if (pick < 93) begin
         r.kind = REQ_CLEAR;
      end else begin
         r.kind = REQ_UNUSED;
      end
      return r;
   endfunction

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      hist_req_type r;
      int unsigned counted;
      tally = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset setup: empty window, nothing can be binned
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd0));
      send_item(req_item(REQ_RECORD, '0, '0, '0, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd0));
      send_item(req_item(REQ_UNUSED, '1, '1, '1, '1));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd1023));

      // full-range box and window, unit width: bucket count caps
      cfg_vals[CSR_BOX_MIN_X] = 48'hffff_8000_0000;
      cfg_vals[CSR_BOX_MAX_X] = 48'h0000_7fff_ffff;
      cfg_vals[CSR_BOX_MIN_Y] = 48'hffff_8000_0000;
      cfg_vals[CSR_BOX_MAX_Y] = 48'h0000_7fff_ffff;
      cfg_vals[CSR_WINDOW_START] = 48'h8000_0000_0000;
      cfg_vals[CSR_WINDOW_END] = 48'h7fff_ffff_ffff;
      cfg_vals[CSR_BUCKET_WIDTH] = 48'd1;
      settle_and_program();
      send_item(req_item(REQ_RECORD, 32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000, '0));
      send_item(req_item(REQ_RECORD, 32'h7fff_ffff, 32'h7fff_ffff, 48'h8000_0000_03ff, '0));
      send_item(req_item(REQ_RECORD, '0, '0, 48'h8000_0000_0400, '0));
      send_item(req_item(REQ_RECORD, '0, '0, 48'h7fff_ffff_ffff, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd1023));
      send_item(req_item(REQ_CLEAR, '0, '0, '0, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd0));

      // zero width acts as one; five buckets, point box at the origin
      cfg_vals[CSR_BOX_MIN_X] = '0;
      cfg_vals[CSR_BOX_MAX_X] = '0;
      cfg_vals[CSR_BOX_MIN_Y] = '0;
      cfg_vals[CSR_BOX_MAX_Y] = '0;
      cfg_vals[CSR_WINDOW_START] = 48'd100;
      cfg_vals[CSR_WINDOW_END] = 48'd105;
      cfg_vals[CSR_BUCKET_WIDTH] = '0;
      settle_and_program();
      send_item(req_item(REQ_RECORD, '0, '0, 48'd100, '0));
      send_item(req_item(REQ_RECORD, '0, '0, 48'd104, '0));
      send_item(req_item(REQ_RECORD, '0, '0, 48'd105, '0));
      send_item(req_item(REQ_RECORD, 32'd1, '0, 48'd100, '0));
      send_item(req_item(REQ_RECORD, '0, '0, 48'd99, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd4));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd5));

      // reversed window, widest bucket
      cfg_vals[CSR_BOX_MIN_X] = 48'hffff_8000_0000;
      cfg_vals[CSR_BOX_MAX_X] = 48'h0000_7fff_ffff;
      cfg_vals[CSR_BOX_MIN_Y] = 48'hffff_8000_0000;
      cfg_vals[CSR_BOX_MAX_Y] = 48'h0000_7fff_ffff;
      cfg_vals[CSR_WINDOW_START] = 48'd1000;
      cfg_vals[CSR_WINDOW_END] = 48'd500;
      cfg_vals[CSR_BUCKET_WIDTH] = 48'hffff_ffff;
      settle_and_program();
      send_item(req_item(REQ_RECORD, '0, '0, 48'd700, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd0));

      // full window, widest bucket
      cfg_vals[CSR_WINDOW_START] = 48'h8000_0000_0000;
      cfg_vals[CSR_WINDOW_END] = 48'h7fff_ffff_ffff;
      settle_and_program();
      send_item(req_item(REQ_RECORD, '0, '0, 48'h8004_ffff_fffb, '0));
      send_item(req_item(REQ_READ, '0, '0, '0, 10'd5));

      for (int p = 0; p < RANDOM_SETUPS; p++) begin
         pick_setup();
         settle_and_program();
         counted = 0;
         while (counted < ITEMS_PER_SETUP) begin
            r = random_item();
            send_item(r);
            if (r.kind != REQ_UNUSED) counted++;
            if (counted == ITEMS_PER_SETUP / 2) drain_results();
         end
      end

      drain_results();
      repeat (QUIET_CYCLES) @(posedge clock);
      tally.failures += tally.pending_reads.size();
      $display("Run covered %0d transfers over %0d register setups: %0d reads checked,",
               tally.transfers, RANDOM_SETUPS + 5, tally.reads_checked);
      $display("%0d points binned, %0d clears, %0d failures",
               tally.points_binned, tally.clears_seen, tally.failures);
      if (tally.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bthist_pkg.sv
rtl/core/bthist_ram.sv
rtl/core/box_time_bucket_histogram_unit.sv
tb/sv/tb.sv
